[rtl/bitstream_header_strip_macros.svh]
//------------------------------------------------------------------------------
// Assertion macros for the bitstream header strip block
// Shared concurrent assertion forms. Each expects clk and rst_n in scope.
//------------------------------------------------------------------------------
`ifndef BITSTREAM_HEADER_STRIP_MACROS_SVH
`define BITSTREAM_HEADER_STRIP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define BHS_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define BHS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/bhs_pkg.sv]
//------------------------------------------------------------------------------
// Bitstream header strip package
// Types, codes and constant tables shared by the header strip modules.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

package bhs_pkg;

    // Parse phases of the configuration file.
    typedef enum logic [3:0] {
        PH_HDR  = 4'd0,
        PH_KEY  = 4'd1,
        PH_SLEN = 4'd2,
        PH_SKIP = 4'd3,
        PH_ELEN = 4'd4,
        PH_PAY  = 4'd5
    } phase_t;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_BAD_HEADER = 2'd1,
        ST_BAD_KEY    = 2'd2,
        ST_SHORT      = 2'd3
    } status_t;

    // One result request.
    typedef struct packed {
        logic [7:0]  out_byte;
        logic        has_data;
        logic        done_res;
        status_t     status;
        logic [31:0] payload_length;
    } bhs_result_t;

    localparam int unsigned PREAMBLE_LEN = 13;
    localparam logic [3:0]  PREAMBLE_LAST_IDX = 4'(PREAMBLE_LEN - 1);
    localparam logic [7:0]  KEY_FIRST = 8'h61;      // 'a'
    localparam logic [2:0]  KEY_PAYLOAD_IDX = 3'd4; // field 'e'
    localparam logic [31:0] SEEN_MAX = 32'hFFFF_FFFF;

    // Fixed preamble that opens every configuration file.
    function automatic logic [7:0] preamble_byte(input logic [3:0] idx);
        logic [7:0] val;
        case (idx)
            4'd0:    val = 8'h00;
            4'd1:    val = 8'h09;
            4'd2:    val = 8'h0f;
            4'd3:    val = 8'hf0;
            4'd4:    val = 8'h0f;
            4'd5:    val = 8'hf0;
            4'd6:    val = 8'h0f;
            4'd7:    val = 8'hf0;
            4'd8:    val = 8'h0f;
            4'd9:    val = 8'hf0;
            4'd10:   val = 8'h00;
            4'd11:   val = 8'h00;
            4'd12:   val = 8'h01;
            default: val = 8'h00;
        endcase
        return val;
    endfunction

    // Mirror the bit order of a byte.
    function automatic logic [7:0] rev_bits(input logic [7:0] v);
        logic [7:0] r;
        for (int i = 0; i < 8; i++)
        begin
            r[7 - i] = v[i];
        end
        return r;
    endfunction

endpackage

[rtl/bhs_if.sv]
//------------------------------------------------------------------------------
// Bitstream header strip channel interfaces
// Valid/ready channels for raw file bytes in and parse results out.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

// Raw byte channel.
interface bhs_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       last_byte;

    modport source (output valid, output in_byte, output last_byte, input ready);
    modport sink   (input valid, input in_byte, input last_byte, output ready);
endinterface

// Result channel.
interface bhs_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  out_byte;
    logic        has_data;
    logic        done_res;
    logic [1:0]  status;
    logic [31:0] payload_length;

    modport source (output valid, output out_byte, output has_data, output done_res,
                    output status, output payload_length, input ready);
    modport sink   (input valid, input out_byte, input has_data, input done_res,
                    input status, input payload_length, output ready);
endinterface

[rtl/bhs_parser.sv]
//------------------------------------------------------------------------------
// Bitstream header strip parser
// Header state machine: consumes one byte per step and forms its result.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "bitstream_header_strip_macros.svh"

module bhs_parser
    import bhs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step_valid,
    input  logic [7:0]  step_byte,
    input  logic        step_last,
    output logic        res_valid,
    output bhs_result_t res
);

    phase_t      phase_reg, phase_next;
    logic [3:0]  byte_index_reg, byte_index_next;
    logic [2:0]  field_index_reg, field_index_next;
    logic [15:0] skip_count_reg, skip_count_next;
    logic [31:0] declared_length_reg, declared_length_next;
    logic [31:0] payload_seen_reg, payload_seen_next;
    logic        discarding_reg, discarding_next;

    logic [3:0]  hdr_idx;
    logic        hdr_ok;
    logic        key_ok;
    logic [15:0] skip_shift;
    logic [15:0] skip_dec;
    logic [31:0] len_shift;
    logic [31:0] seen_inc;

    // Shared datapath terms.
    assign hdr_idx    = (phase_reg == PH_HDR) ? byte_index_reg : 4'd0;
    assign hdr_ok     = (hdr_idx < 4'(PREAMBLE_LEN)) && (step_byte == preamble_byte(hdr_idx));
    assign key_ok     = (field_index_reg <= KEY_PAYLOAD_IDX)
                        && (step_byte == (KEY_FIRST + {5'd0, field_index_reg}));
    assign skip_shift = {skip_count_reg[7:0], step_byte};
    assign skip_dec   = skip_count_reg - 16'd1;
    assign len_shift  = {declared_length_reg[23:0], step_byte};
    assign seen_inc   = (payload_seen_reg == SEEN_MAX) ? payload_seen_reg
                                                       : payload_seen_reg + 32'd1;

    // Next state for one step.
    always_comb
    begin
        phase_next           = phase_reg;
        byte_index_next      = byte_index_reg;
        field_index_next     = field_index_reg;
        skip_count_next      = skip_count_reg;
        declared_length_next = declared_length_reg;
        payload_seen_next    = payload_seen_reg;
        discarding_next      = discarding_reg;

        if (discarding_reg)
        begin
            // Drop everything up to the end of the file.
            if (step_last)
            begin
                phase_next           = PH_HDR;
                byte_index_next      = 4'd0;
                field_index_next     = 3'd0;
                skip_count_next      = 16'd0;
                declared_length_next = 32'd0;
                payload_seen_next    = 32'd0;
                discarding_next      = 1'b0;
            end
        end
        else
        begin
            case (phase_reg)
                PH_KEY:
                begin
                    if (!step_last && key_ok)
                    begin
                        byte_index_next = 4'd0;
                        if (field_index_reg == KEY_PAYLOAD_IDX)
                        begin
                            phase_next           = PH_ELEN;
                            declared_length_next = 32'd0;
                        end
                        else
                        begin
                            phase_next      = PH_SLEN;
                            skip_count_next = 16'd0;
                        end
                    end
                end
                PH_SLEN:
                begin
                    if (!step_last)
                    begin
                        skip_count_next = skip_shift;
                        if (byte_index_reg >= 4'd1)
                        begin
                            field_index_next = field_index_reg + 3'd1;
                            byte_index_next  = 4'd0;
                            phase_next       = (skip_shift != 16'd0) ? PH_SKIP : PH_KEY;
                        end
                        else
                        begin
                            byte_index_next = byte_index_reg + 4'd1;
                        end
                    end
                end
                PH_SKIP:
                begin
                    if (!step_last)
                    begin
                        skip_count_next = skip_dec;
                        if (skip_dec == 16'd0)
                        begin
                            phase_next = PH_KEY;
                        end
                    end
                end
                PH_ELEN:
                begin
                    declared_length_next = len_shift;
                    if (byte_index_reg >= 4'd3)
                    begin
                        if (!step_last)
                        begin
                            phase_next        = PH_PAY;
                            byte_index_next   = 4'd0;
                            payload_seen_next = 32'd0;
                        end
                    end
                    else
                    begin
                        byte_index_next = byte_index_reg + 4'd1;
                    end
                end
                PH_PAY:
                begin
                    payload_seen_next = seen_inc;
                end
                default:
                begin
                    // Header check; any stray phase restarts at byte zero.
                    if (phase_reg != PH_HDR)
                    begin
                        phase_next           = PH_HDR;
                        byte_index_next      = 4'd0;
                        field_index_next     = 3'd0;
                        skip_count_next      = 16'd0;
                        declared_length_next = 32'd0;
                        payload_seen_next    = 32'd0;
                    end
                    if (hdr_ok && !step_last)
                    begin
                        if (hdr_idx == PREAMBLE_LAST_IDX)
                        begin
                            phase_next       = PH_KEY;
                            byte_index_next  = 4'd0;
                            field_index_next = 3'd0;
                        end
                        else
                        begin
                            byte_index_next = hdr_idx + 4'd1;
                        end
                    end
                end
            endcase

            // The last byte always starts a new file; an error otherwise discards.
            if (step_last)
            begin
                phase_next           = PH_HDR;
                byte_index_next      = 4'd0;
                field_index_next     = 3'd0;
                skip_count_next      = 16'd0;
                declared_length_next = 32'd0;
                payload_seen_next    = 32'd0;
                discarding_next      = 1'b0;
            end
            else if (res_valid && !res.has_data)
            begin
                discarding_next = 1'b1;
            end
        end
    end

    // Result for one step.
    always_comb
    begin
        res_valid          = 1'b0;
        res.out_byte       = 8'd0;
        res.has_data       = 1'b0;
        res.done_res       = 1'b1;
        res.status         = ST_OK;
        res.payload_length = 32'd0;

        if (!discarding_reg)
        begin
            case (phase_reg)
                PH_KEY:
                begin
                    if (step_last)
                    begin
                        res_valid  = 1'b1;
                        res.status = ST_SHORT;
                    end
                    else if (!key_ok)
                    begin
                        res_valid  = 1'b1;
                        res.status = ST_BAD_KEY;
                    end
                end
                PH_SLEN, PH_SKIP:
                begin
                    if (step_last)
                    begin
                        res_valid  = 1'b1;
                        res.status = ST_SHORT;
                    end
                end
                PH_ELEN:
                begin
                    if (step_last)
                    begin
                        res_valid = 1'b1;
                        if (byte_index_reg >= 4'd3)
                        begin
                            res.status         = (len_shift != 32'd0) ? ST_SHORT : ST_OK;
                            res.payload_length = len_shift;
                        end
                        else
                        begin
                            res.status = ST_SHORT;
                        end
                    end
                end
                PH_PAY:
                begin
                    res_valid          = 1'b1;
                    res.out_byte       = rev_bits(step_byte);
                    res.has_data       = 1'b1;
                    res.done_res       = step_last;
                    res.status         = (step_last && (seen_inc < declared_length_reg))
                                         ? ST_SHORT : ST_OK;
                    res.payload_length = declared_length_reg;
                end
                default:
                begin
                    if (!hdr_ok)
                    begin
                        res_valid  = 1'b1;
                        res.status = ST_BAD_HEADER;
                    end
                    else if (step_last)
                    begin
                        res_valid  = 1'b1;
                        res.status = (hdr_idx == PREAMBLE_LAST_IDX) ? ST_SHORT
                                                                    : ST_BAD_HEADER;
                    end
                end
            endcase
        end
    end

    // Parser state registers advance once per processed byte.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg           <= PH_HDR;
            byte_index_reg      <= 4'd0;
            field_index_reg     <= 3'd0;
            skip_count_reg      <= 16'd0;
            declared_length_reg <= 32'd0;
            payload_seen_reg    <= 32'd0;
            discarding_reg      <= 1'b0;
        end
        else if (step_valid)
        begin
            phase_reg           <= phase_next;
            byte_index_reg      <= byte_index_next;
            field_index_reg     <= field_index_next;
            skip_count_reg      <= skip_count_next;
            declared_length_reg <= declared_length_next;
            payload_seen_reg    <= payload_seen_next;
            discarding_reg      <= discarding_next;
        end
    end

    // Checks on the parser.
    `BHS_ASSERT_IMPL(a_data_only_in_payload, res_valid && res.has_data, phase_reg == PH_PAY, "payload byte outside payload phase")
    `BHS_ASSERT_IMPL(a_silent_while_discarding, discarding_reg, !res_valid, "result while discarding")
    `BHS_ASSERT_NEXT(a_last_restarts, step_valid && step_last, phase_reg == PH_HDR && byte_index_reg == 4'd0 && !discarding_reg, "last byte did not restart")
    `BHS_ASSERT_IMPL(a_error_is_final, res_valid && !res.has_data, res.done_res && res.out_byte == 8'd0, "status result not final")

endmodule

[rtl/bitstream_header_strip.sv]
//------------------------------------------------------------------------------
// Bitstream header strip
// Strips the header of an FPGA configuration file and passes the payload on.
//------------------------------------------------------------------------------
// The block takes one file byte per cycle while the result side keeps up, and
// gives at most one result per byte. A byte accepted on the input channel
// lands in the input register, is parsed from there into the result register
// and is offered on the result channel from then on. The input register is
// refilled in the same cycle that it drains into the result register, so one
// byte per cycle is kept up as long as the result side takes a result every
// cycle; a stalled result holds both registers. Bytes that give no result (the
// header, the field keys and lengths, the skipped field text, and everything
// after an error) still pass through the input register at one per cycle
// while no result is stalled.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "bitstream_header_strip_macros.svh"

module bitstream_header_strip
    import bhs_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    bhs_in_if.sink           in_ch,
    bhs_out_if.source        out_ch
);

    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        in_last_reg;
    logic        out_valid_reg, out_valid_next;
    bhs_result_t out_data_reg;
    logic        advance;
    logic        res_valid;
    bhs_result_t res;

    // A buffered byte moves on when the result register is free or draining.
    assign advance     = in_valid_reg && (!out_valid_reg || out_ch.ready);
    assign in_ch.ready = !in_valid_reg || advance;

    bhs_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .step_valid (advance),
        .step_byte  (in_byte_reg),
        .step_last  (in_last_reg),
        .res_valid  (res_valid),
        .res        (res)
    );

    // Input register control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ch.ready)
        begin
            in_valid_reg <= in_ch.valid;
        end
    end

    // Input register payload.
    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            in_byte_reg <= in_ch.in_byte;
            in_last_reg <= in_ch.last_byte;
        end
    end

    // Result register occupancy.
    always_comb
    begin
        if (advance)
        begin
            out_valid_next = res_valid;
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Result register payload.
    always_ff @(posedge clk)
    begin
        if (advance && res_valid)
        begin
            out_data_reg <= res;
        end
    end

    // Result channel.
    assign out_ch.valid          = out_valid_reg;
    assign out_ch.out_byte       = out_data_reg.out_byte;
    assign out_ch.has_data       = out_data_reg.has_data;
    assign out_ch.done_res       = out_data_reg.done_res;
    assign out_ch.status         = out_data_reg.status;
    assign out_ch.payload_length = out_data_reg.payload_length;

    // Checks on the buffering.
    `BHS_ASSERT_NEXT(a_in_held_on_stall, in_valid_reg && !advance, in_valid_reg, "buffered byte lost")
    `BHS_ASSERT_NEXT(a_result_loaded, advance && res_valid, out_valid_reg, "parser result not registered")
    `BHS_ASSERT_NEXT(a_no_phantom_result, !out_valid_reg && !advance, !out_valid_reg, "result appeared without a byte")

endmodule
